// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion reporting via $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property: expr must hold at every sampled edge out of reset.
`define IRFM_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Implication into the next cycle: cond at one edge forces expr at the next.
`define IRFM_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/irfm_pkg.sv =====
// Types and codes for the IR key to function map.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package irfm_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  key_protocol;
        logic [15:0] key_address;
        logic [15:0] key_command;
        logic [7:0]  function_in;
    } t_in_req;

    typedef struct packed {
        logic        found;
        logic [7:0]  function_out;
        logic        success;
        logic [5:0]  entries_used;
    } t_out_rsp;

    // one stored table entry
    typedef struct packed {
        logic [7:0]  protocol;
        logic [15:0] address;
        logic [15:0] command;
        logic [7:0]  func_code;
    } t_entry;

    // control handed from the sequencer to the entry chain
    typedef struct packed {
        logic   shift;
        t_entry feed;
    } t_chain_ctl;

endpackage

`default_nettype wire

// ===== sv/irfm_cell.sv =====
// One table slot of the entry ring: holds an entry, takes its neighbor's on shift.
// Depends on irfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irfm_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire irfm_pkg::t_entry i_next,
    output irfm_pkg::t_entry     o_entry
);

    irfm_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== sv/irfm_chain.sv =====
// Ring of table cells: each shift moves every entry one slot toward the head,
// and the tail takes the feed entry. Depends on irfm_pkg and irfm_cell.
`timescale 1ns / 1ps
`default_nettype none

module irfm_chain #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                i_clk,
    input  wire irfm_pkg::t_chain_ctl i_ctl,
    output irfm_pkg::t_entry         o_head
);

    irfm_pkg::t_entry w_q [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        irfm_pkg::t_entry w_next;
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign w_next = i_ctl.feed;
        end else begin : g_body
            assign w_next = w_q[g + 1];
        end
        irfm_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_next  (w_next),
            .o_entry (w_q[g])
        );
    end

    assign o_head = w_q[0];

endmodule

`default_nettype wire

// ===== sv/ir_code_function_map_core.sv =====
// IR key to function map, top level: request sequencer over a ring of entry cells.
// Depends on irfm_pkg, irfm_chain (and through it irfm_cell).
//
// Input channel (i_in_valid / o_in_ready, i_in_data) carries one request:
// lookup, learn or forget. Output channel (o_out_valid / i_out_ready,
// o_out_data) returns exactly one response per request, in order.
// Every request rotates the entry ring through one full pass, with one
// compare unit watching the head cell. Lookup and the unused code take
// one pass. Learn and forget take a second pass that writes the changed
// entries back in at the tail.
// One request is in work at a time; a new request is taken as soon as the
// previous response is loaded in the output register, even while that
// response still waits. If the receiver stalls with a response pending and
// another one is finished, the sequencer holds until the register frees.
// Synchronous reset empties the table at once (count to zero); cell
// contents are left as they are and are never read beyond the count.
`timescale 1ns / 1ps
`default_nettype none

module ir_code_function_map_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire irfm_pkg::t_in_req i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output irfm_pkg::t_out_rsp     o_out_data
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PASS1  = 2'd1;
    localparam logic [1:0] S_PASS2  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    irfm_pkg::t_in_req    r_req;
    logic [CW-1:0]        r_step;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_fm;
    logic [CW-1:0]        r_m;
    logic                 r_km;
    logic [CW-1:0]        r_j;
    logic [7:0]           r_jfunc;
    logic                 r_succ;
    irfm_pkg::t_entry     r_hold;
    logic                 r_out_valid;
    irfm_pkg::t_out_rsp   r_out;

    irfm_pkg::t_entry     w_head;
    irfm_pkg::t_entry     w_new;
    irfm_pkg::t_chain_ctl w_ctl;
    logic                 w_accept;
    logic                 w_lookup;
    logic                 w_learn;
    logic                 w_forget;
    logic                 w_in_use;
    logic                 w_key_eq;
    logic                 w_fmatch;
    logic                 w_kmatch;
    logic                 w_is_last;
    logic                 w_last_step;
    logic                 w_kj;
    logic [CW-1:0]        w_c1;
    logic                 w_room;
    logic                 w_append;
    logic [CW+5:0]        w_cnt_ext;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_lookup    = r_req.operation == irfm_pkg::OP_LOOKUP;
    assign w_learn     = r_req.operation == irfm_pkg::OP_LEARN;
    assign w_forget    = r_req.operation == irfm_pkg::OP_FORGET;

    assign w_in_use    = r_step < r_count;
    assign w_key_eq    = w_head.protocol == r_req.key_protocol &&
                         w_head.address  == r_req.key_address  &&
                         w_head.command  == r_req.key_command;
    assign w_fmatch    = w_in_use && (w_learn || w_forget) &&
                         w_head.func_code == r_req.function_in;
    assign w_kmatch    = w_in_use && (w_lookup || w_learn) && w_key_eq;
    assign w_is_last   = (CW+1)'(r_step) + (CW+1)'(1) == (CW+1)'(r_count);
    assign w_last_step = r_step == CW'(TABLE_ENTRIES - 1);

    // second-pass decisions; functions and keys are each unique in the table
    assign w_kj     = r_km && !(r_fm && r_j == r_m);
    assign w_c1     = r_fm ? r_count - CW'(1) : r_count;
    assign w_room   = w_c1 < CW'(TABLE_ENTRIES);
    assign w_append = w_learn && !w_kj && w_room;

    assign w_new.protocol  = r_req.key_protocol;
    assign w_new.address   = r_req.key_address;
    assign w_new.command   = r_req.key_command;
    assign w_new.func_code = r_req.function_in;

    always_comb begin
        w_ctl.shift = (r_state == S_PASS1) || (r_state == S_PASS2);
        w_ctl.feed  = w_head;
        if (r_state == S_PASS2) begin
            if (w_learn && w_kj && r_step == r_j) begin
                w_ctl.feed.func_code = r_req.function_in;
            end
            // hole left by the forgotten function takes the old last entry
            if (r_fm && r_step == r_m) begin
                w_ctl.feed = r_hold;
            end
            if (w_append && r_step == w_c1) begin
                w_ctl.feed = w_new;
            end
        end
    end

    irfm_chain #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PASS1;
                end
            end
            S_PASS1: begin
                if (w_last_step) begin
                    n_state = (w_learn || w_forget) ? S_PASS2 : S_FINISH;
                end
            end
            S_PASS2: begin
                if (w_last_step) begin
                    n_state = S_FINISH;
                    n_count = w_append ? w_c1 + CW'(1) : w_c1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_FINISH && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cnt_ext = {6'b0, r_count};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req  <= i_in_data;
                    r_step <= '0;
                    r_fm   <= 1'b0;
                    r_km   <= 1'b0;
                    r_succ <= 1'b0;
                end
            end
            S_PASS1: begin
                r_step <= w_last_step ? '0 : r_step + CW'(1);
                if (w_fmatch) begin
                    r_fm <= 1'b1;
                    r_m  <= r_step;
                end
                if (w_kmatch) begin
                    r_km    <= 1'b1;
                    r_j     <= r_step;
                    r_jfunc <= w_head.func_code;
                end
                if (w_in_use && w_is_last) begin
                    r_hold.protocol  <= w_head.protocol;
                    r_hold.address   <= w_head.address;
                    r_hold.command   <= w_head.command;
                    r_hold.func_code <= (w_learn && w_key_eq) ? r_req.function_in
                                                               : w_head.func_code;
                end
            end
            S_PASS2: begin
                r_step <= w_last_step ? '0 : r_step + CW'(1);
                if (w_last_step) begin
                    r_succ <= w_learn && (w_kj || w_room);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.found        <= w_lookup && r_km;
                    r_out.function_out <= (w_lookup && r_km) ? r_jfunc : 8'd0;
                    r_out.success      <= r_succ;
                    r_out.entries_used <= w_cnt_ext[5:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/irfm_checker.sv =====
// Port-level checks for ir_code_function_map_core, attached by bind below.
// Depends on irfm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irfm_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire irfm_pkg::t_in_req  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire irfm_pkg::t_out_rsp o_out_data
);

    logic w_in_acc;
    logic w_in_wait;
    logic w_stall;
    logic [31:0] w_used;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_in_wait = i_in_valid && !o_in_ready;
    assign w_stall   = o_out_valid && !i_out_ready;
    assign w_used    = {26'b0, o_out_data.entries_used};

    // an accepted request makes the sequencer busy: input ready drops after the accept
    `IRFM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_in_acc, !o_in_ready, "ready after request")

    `IRFM_ASSERT_NEXT(a_req_hold, i_clk, i_rst_n, w_in_wait, i_in_valid && $stable(i_in_data), "waiting request changed")

    `IRFM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(o_out_data), "stalled response changed")

    // lookup fields and learn status never show together; a miss reads zero
    `IRFM_ASSERT(a_rsp_fields, i_clk, i_rst_n, !o_out_valid || ((!o_out_data.found || !o_out_data.success) && (o_out_data.found || o_out_data.function_out == 8'd0)), "inconsistent response fields")

    `IRFM_ASSERT(a_count_bound, i_clk, i_rst_n, !o_out_valid || w_used <= TABLE_ENTRIES, "entry count above table size")

endmodule

bind ir_code_function_map_core irfm_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_irfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/tb_ir_code_function_map_core.sv =====
// Self-checking bench for ir_code_function_map_core: random and directed requests
// against a behavioral model of the key table. Depends on irfm_pkg and the core.
`timescale 1ns / 1ps

module tb_ir_code_function_map_core;

    localparam int         TABLE_ENTRIES = 32;
    localparam int         CLK_HALF      = 4;
    localparam int         STALL_CYCLES  = 700;
    localparam int         HOLD1_AT      = 12000;
    localparam int         HOLD2_AT      = 40000;
    localparam int         RANDOM_ITEMS  = 1425;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               req_valid   = 1'b0;
    irfm_pkg::t_in_req  req_data    = '0;
    logic               rsp_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    irfm_pkg::t_out_rsp o_out_data;

    ir_code_function_map_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (req_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // model of the key table
    irfm_pkg::t_entry key_table [TABLE_ENTRIES];
    int     key_count = 0;
    int     peak_count = 0;

    irfm_pkg::t_in_req  req_backlog [$];
    irfm_pkg::t_out_rsp answers_due [$];

    int total_reqs = 0;
    int sent_reqs  = 0;
    int rsp_seen   = 0;
    int fail_count = 0;
    int n_lookup = 0, n_hit = 0, n_learn = 0, n_refused = 0, n_forget = 0, n_unused = 0;

    int tx_wait = 0, tx_quiet = 0;
    int rx_wait = 0, rx_quiet = 0;
    int   hold_cyc = 0;
    logic hold_on  = 1'b0;

    // key pool so that learns, lookups and forgets keep hitting the same entries
    logic [7:0]  pool_p [64];
    logic [15:0] pool_a [64];
    logic [15:0] pool_c [64];
    logic [7:0]  func_base;

    function automatic bit key_hit(int idx, irfm_pkg::t_in_req rq);
        return key_table[idx].protocol == rq.key_protocol &&
               key_table[idx].address  == rq.key_address  &&
               key_table[idx].command  == rq.key_command;
    endfunction

    // drop every entry holding func, last entry moves into the hole
    function automatic void drop_function(logic [7:0] func);
        int i;
        i = 0;
        while (i < key_count) begin
            if (key_table[i].func_code == func) begin
                key_table[i] = key_table[key_count - 1];
                key_count--;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic irfm_pkg::t_out_rsp table_apply(irfm_pkg::t_in_req rq);
        irfm_pkg::t_out_rsp rsp;
        int       i;
        bit       hit;
        rsp = '0;
        hit = 1'b0;
        case (rq.operation)
            irfm_pkg::OP_LOOKUP: begin
                n_lookup++;
                for (i = 0; i < key_count && !hit; i++) begin
                    if (key_hit(i, rq)) begin
                        hit              = 1'b1;
                        rsp.found        = 1'b1;
                        rsp.function_out = key_table[i].func_code;
                    end
                end
                if (hit) n_hit++;
            end
            irfm_pkg::OP_LEARN: begin
                n_learn++;
                drop_function(rq.function_in);
                for (i = 0; i < key_count && !hit; i++) begin
                    if (key_hit(i, rq)) begin
                        hit                    = 1'b1;
                        key_table[i].func_code = rq.function_in;
                    end
                end
                if (!hit && key_count < TABLE_ENTRIES) begin
                    key_table[key_count] = '{protocol: rq.key_protocol,
                                             address: rq.key_address,
                                             command: rq.key_command,
                                             func_code: rq.function_in};
                    key_count++;
                    hit = 1'b1;
                end
                if (!hit) n_refused++;
                rsp.success = hit;
            end
            irfm_pkg::OP_FORGET: begin
                n_forget++;
                drop_function(rq.function_in);
            end
            default: n_unused++;
        endcase
        if (key_count > peak_count) peak_count = key_count;
        rsp.entries_used = key_count[5:0];
        return rsp;
    endfunction

    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = 20 + $urandom_range(0, 20);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    task automatic queue_req(input logic [1:0] op, input logic [7:0] p, input logic [15:0] a,
                             input logic [15:0] c, input logic [7:0] f);
        irfm_pkg::t_in_req rq;
        rq = '{operation: op, key_protocol: p, key_address: a, key_command: c,
               function_in: f};
        req_backlog.push_back(rq);
    endtask

    task automatic queue_pool_req(input logic [1:0] op, input int k, input logic [7:0] f);
        queue_req(op, pool_p[k], pool_a[k], pool_c[k], f);
    endtask

    // sender: one request at a time, random gap after each accept
    always @(posedge i_clk) begin : drive_req
        irfm_pkg::t_out_rsp want;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && o_in_ready) begin
                want = table_apply(req_data);
                answers_due.push_back(want);
                sent_reqs++;
                tx_wait = draw_idle(tx_quiet);
            end
            if (req_valid && !o_in_ready) begin
                // hold the offered request
            end else if (tx_wait > 0) begin
                tx_wait--;
                req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                req_data  <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // long hold-off windows so the core backs up onto its input
    always @(posedge i_clk) begin : hold_off
        if (i_rst_n) begin
            hold_cyc++;
            hold_on <= (hold_cyc >= HOLD1_AT && hold_cyc < HOLD1_AT + STALL_CYCLES) ||
                       (hold_cyc >= HOLD2_AT && hold_cyc < HOLD2_AT + STALL_CYCLES);
        end
    end

    // receiver: check each response, then stall the next one at random
    always @(posedge i_clk) begin : watch_rsp
        irfm_pkg::t_out_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && rsp_ready) begin
                if (answers_due.size() == 0) begin
                    note_failure($sformatf("%0t: response with no request pending", $time));
                end else begin
                    want = answers_due.pop_front();
                    if (o_out_data.found !== want.found ||
                        o_out_data.function_out !== want.function_out ||
                        o_out_data.success !== want.success ||
                        o_out_data.entries_used !== want.entries_used) begin
                        note_failure($sformatf(
                            "%0t: mismatch exp found=%0d func=%02h ok=%0d used=%0d, got %0d %02h %0d %0d",
                            $time, want.found, want.function_out, want.success,
                            want.entries_used, o_out_data.found, o_out_data.function_out,
                            o_out_data.success, o_out_data.entries_used));
                    end
                end
                rsp_seen++;
                rx_wait = draw_idle(rx_quiet);
            end
            if (hold_on) begin
                rsp_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                if (o_out_valid) rx_wait--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_800_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main_seq
        int k, n, j, mode, rand_start;
        logic [1:0] op;

        for (k = 0; k < 64; k++) begin
            pool_p[k] = 8'($urandom);
            pool_a[k] = 16'($urandom);
            pool_c[k] = 16'($urandom);
        end
        pool_p[0] = 8'h00; pool_a[0] = 16'h0000; pool_c[0] = 16'h0000;
        pool_p[1] = 8'hff; pool_a[1] = 16'hffff; pool_c[1] = 16'hffff;

        // directed: empty table, extreme keys, rewrite, forget with swap, unused code
        queue_req(irfm_pkg::OP_LOOKUP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        queue_req(OP_UNUSED,           8'hff, 16'hffff, 16'hffff, 8'hff);
        queue_req(irfm_pkg::OP_FORGET, 8'h00, 16'h0000, 16'h0000, 8'h00);
        queue_req(irfm_pkg::OP_LEARN,  8'h00, 16'h0000, 16'h0000, 8'h00);
        queue_req(irfm_pkg::OP_LEARN,  8'hff, 16'hffff, 16'hffff, 8'hff);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        queue_req(irfm_pkg::OP_LOOKUP, 8'hff, 16'hffff, 16'hffff, 8'h00);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h00, 16'h0000, 16'h0001, 8'h00);
        queue_req(irfm_pkg::OP_LOOKUP, 8'hff, 16'hffff, 16'hfffe, 8'h00);
        queue_req(irfm_pkg::OP_LEARN,  8'hff, 16'hffff, 16'hffff, 8'h5a);
        queue_req(irfm_pkg::OP_LEARN,  8'h12, 16'h3456, 16'h789a, 8'h00);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h12, 16'h3456, 16'h789a, 8'h00);
        queue_req(irfm_pkg::OP_LEARN,  8'ha5, 16'h5a5a, 16'ha5a5, 8'h5a);
        queue_req(irfm_pkg::OP_LEARN,  8'h12, 16'h3456, 16'h789a, 8'h33);
        queue_req(irfm_pkg::OP_FORGET, 8'h00, 16'h0000, 16'h0000, 8'h5a);
        queue_req(irfm_pkg::OP_FORGET, 8'h00, 16'h0000, 16'h0000, 8'h77);
        queue_req(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        queue_req(irfm_pkg::OP_LOOKUP, 8'ha5, 16'h5a5a, 16'ha5a5, 8'h00);
        queue_req(irfm_pkg::OP_LEARN,  8'h01, 16'h0002, 16'h0003, 8'h80);
        queue_req(irfm_pkg::OP_LEARN,  8'h04, 16'h0005, 16'h0006, 8'h01);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h04, 16'h0005, 16'h0006, 8'h00);
        queue_req(irfm_pkg::OP_FORGET, 8'h00, 16'h0000, 16'h0000, 8'h33);
        queue_req(irfm_pkg::OP_LOOKUP, 8'h04, 16'h0005, 16'h0006, 8'h00);

        // random episodes: fill past capacity, mixed traffic, drain by forget
        rand_start = req_backlog.size();
        func_base  = 8'($urandom);
        mode       = 0;
        while (req_backlog.size() - rand_start < RANDOM_ITEMS) begin
            if (mode <= 2) begin
                func_base = 8'($urandom);
                k = $urandom_range(0, 63);
                n = $urandom_range(34, 40);
                for (j = 0; j < n; j++)
                    queue_pool_req(irfm_pkg::OP_LEARN, (k + j) % 64, func_base + j[7:0]);
                for (j = 0; j < 4; j++)
                    queue_pool_req(irfm_pkg::OP_LOOKUP, $urandom_range(0, 63), 8'($urandom));
            end else if (mode <= 7) begin
                for (j = 0; j < 60; j++) begin
                    n = $urandom_range(0, 99);
                    if (n < 40)      op = irfm_pkg::OP_LOOKUP;
                    else if (n < 75) op = irfm_pkg::OP_LEARN;
                    else if (n < 95) op = irfm_pkg::OP_FORGET;
                    else             op = OP_UNUSED;
                    if ($urandom_range(0, 9) == 0)
                        queue_req(op, 8'($urandom), 16'($urandom), 16'($urandom),
                                  8'($urandom));
                    else
                        queue_pool_req(op, $urandom_range(0, 63),
                                       func_base + 8'($urandom_range(0, 47)));
                end
            end else begin
                for (j = 0; j < 30; j++) begin
                    if ($urandom_range(0, 9) < 7)
                        queue_pool_req(irfm_pkg::OP_FORGET, 0,
                                       func_base + 8'($urandom_range(0, 39)));
                    else
                        queue_pool_req(irfm_pkg::OP_LOOKUP, $urandom_range(0, 63),
                                       8'($urandom));
                end
            end
            mode = $urandom_range(0, 9);
        end
        total_reqs = req_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_reqs < total_reqs) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_ENTRIES + 10) @(posedge i_clk);

        $display("Ran %0d requests: %0d lookups (%0d hits), %0d learns (%0d refused on full table),",
                 total_reqs, n_lookup, n_hit, n_learn, n_refused);
        $display("%0d forgets, %0d unused codes; peak occupancy %0d, %0d responses, %0d errors",
                 n_forget, n_unused, peak_count, rsp_seen, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
